// File: rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is low
`define CFA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// clocked assertion that is also checked during reset
`define CFA_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: rtl/cfa_pkg.sv
// types and constants of the contiguous fit allocator
`timescale 1ns / 1ps

package cfa_pkg;

  localparam int OWNER_W = 8;
  localparam int SIZE_W  = 9;

  localparam logic [OWNER_W-1:0] OWNER_FREE = '0;

  typedef enum logic [1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_FREE    = 2'd1,
    CMD_COMPACT = 2'd2,
    CMD_READ    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    POL_FIRST = 2'd0,
    POL_BEST  = 2'd1,
    POL_WORST = 2'd2,
    POL_BAD   = 2'd3
  } policy_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NO_SPACE   = 2'd1,
    ST_NOT_FOUND  = 2'd2,
    ST_BAD_POLICY = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_TAIL,
    S_PICK,
    S_FILL,
    S_ZERO,
    S_RD_DATA
  } state_e;

  typedef struct packed {
    cmd_e                command;
    logic [OWNER_W-1:0]  owner_id;
    logic [SIZE_W-1:0]   request_size;
    policy_e             policy;
    logic [7:0]          cell_index;
  } cmd_t;

  typedef struct packed {
    status_e     status;
    logic [7:0]  start_index;
    logic [7:0]  cell_value;
  } res_t;

  typedef struct packed {
    logic clear;
    logic step;
    logic is_free;
  } fit_ctrl_t;

endpackage

// File: rtl/cfa_cell_store.sv
// cell map memory: one write port, one read port with registered data
`timescale 1ns / 1ps

module cfa_cell_store #(
  parameter int DEPTH = 256,
  parameter int AW    = 8,
  parameter int DW    = 8
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/cfa_fit_unit.sv
// free-run tracker and fit comparator, fed one cell per step
`timescale 1ns / 1ps

module cfa_fit_unit #(
  parameter int IDX_W = 8,
  parameter int CNT_W = 9
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cfa_pkg::fit_ctrl_t      ctrl_i,
  input  logic [IDX_W-1:0]        idx_i,
  input  logic [cfa_pkg::SIZE_W-1:0] size_i,
  input  cfa_pkg::policy_e        policy_i,
  output logic                    found_o,
  output logic [IDX_W-1:0]        start_o
);

  import cfa_pkg::*;

  localparam int CMP_W = (CNT_W > SIZE_W) ? CNT_W : SIZE_W;

  logic [CNT_W-1:0] run_len_q;
  logic [CNT_W-1:0] best_len_q;
  logic [IDX_W-1:0] run_start_q;
  logic [IDX_W-1:0] best_start_q;
  logic             found_q;
  logic             fits;
  logic             take;
  logic             grab;

  // run closes on a used cell: does it fit, and does it beat the best so far
  assign fits = (CMP_W'(run_len_q) >= CMP_W'(size_i)) && (run_len_q != '0);
  assign take = !found_q
              || ((policy_i == POL_BEST)  && (run_len_q < best_len_q))
              || ((policy_i == POL_WORST) && (run_len_q > best_len_q));
  assign grab = ctrl_i.step && !ctrl_i.is_free && fits && take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_len_q <= '0;
      found_q   <= 1'b0;
    end else if (ctrl_i.clear) begin
      run_len_q <= '0;
      found_q   <= 1'b0;
    end else if (ctrl_i.step) begin
      if (ctrl_i.is_free) begin
        run_len_q <= run_len_q + CNT_W'(1);
      end else begin
        run_len_q <= '0;
        if (grab) begin
          found_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.step && ctrl_i.is_free && (run_len_q == '0)) begin
      run_start_q <= idx_i;
    end
    if (grab) begin
      best_start_q <= run_start_q;
      best_len_q   <= run_len_q;
    end
  end

  assign found_o = found_q;
  assign start_o = best_start_q;

endmodule

// File: rtl/contiguous_fit_allocator_top.sv
// top level of the contiguous fit allocator: sequencer, cell map and fit unit
`timescale 1ns / 1ps

// usage
// - a command transaction is taken at a rising edge with start high and busy low;
//   cmd_i carries command, owner id, request size, policy and cell index
// - every command gives exactly one result on res_o, shown for one cycle while
//   res_valid_o is high; the receiver cannot stall, so the result is simply taken
// - a new command may be given in the same cycle as the previous result strobe
// - steps from acceptance to strobe, by command:
//     bad policy, zero size, free of owner zero, read beyond the map: answered from idle
//     read one cell: one registered memory read
//     free owner: one read/modify pass
//     allocate: scan pass, then fill
//     compact: move pass, then free tail
// - the rate is set by the single memory port pair: one cell read and one cell
//   written per cycle, with one shared run comparator during allocate scans
// - after reset a clearing pass writes every cell free, with busy high
// - busy stays high while a command is in progress; commands are taken one at a time
module contiguous_fit_allocator_top #(
  parameter int CELL_COUNT = 256
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  cfa_pkg::cmd_t cmd_i,
  output cfa_pkg::res_t res_o,
  output logic          res_valid_o
);

  import cfa_pkg::*;

  localparam int IDX_W = $clog2(CELL_COUNT);
  localparam int CNT_W = $clog2(CELL_COUNT + 1);
  localparam int CMP_W = (CNT_W > SIZE_W) ? CNT_W : SIZE_W;
  localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(CELL_COUNT - 1);
  localparam logic [CNT_W-1:0] END_IDX  = CNT_W'(CELL_COUNT);

  function automatic res_t make_res(status_e st, logic [7:0] start_idx,
                                    logic [7:0] value);
    res_t r;
    r.status      = st;
    r.start_index = start_idx;
    r.cell_value  = value;
    return r;
  endfunction

  // sequencer state
  state_e             state_q, state_d;
  logic [CNT_W-1:0]   addr_q, addr_d;      // read sweep / fill / clear pointer
  logic [CNT_W-1:0]   wptr_q, wptr_d;      // compaction write pointer
  logic [SIZE_W-1:0]  rem_q, rem_d;        // cells still to fill
  logic               rd_vld_q, rd_vld_d;  // memory data valid this cycle
  logic               hit_q, hit_d;
  cmd_e               op_q, op_d;
  res_t               res_q, res_d;
  logic               res_valid_q, res_valid_d;

  // transaction payload held for the duration of a command
  logic [IDX_W-1:0]   rd_idx_q, rd_idx_d;
  logic [OWNER_W-1:0] owner_q, owner_d;
  logic [SIZE_W-1:0]  size_q, size_d;
  policy_e            pol_q, pol_d;

  // memory ports
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  logic [OWNER_W-1:0] mem_wdata;
  logic               mem_re;
  logic [IDX_W-1:0]   mem_raddr;
  logic [OWNER_W-1:0] mem_rdata;

  // fit unit
  fit_ctrl_t          fit_ctrl;
  logic               fit_found;
  logic [IDX_W-1:0]   fit_start;

  logic               accept;

  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;

  cfa_cell_store #(
    .DEPTH (CELL_COUNT),
    .AW    (IDX_W),
    .DW    (OWNER_W)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  cfa_fit_unit #(
    .IDX_W (IDX_W),
    .CNT_W (CNT_W)
  ) u_fit (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (fit_ctrl),
    .idx_i    (rd_idx_q),
    .size_i   (size_q),
    .policy_i (pol_q),
    .found_o  (fit_found),
    .start_o  (fit_start)
  );

  always_comb begin
    state_d     = state_q;
    addr_d      = addr_q;
    wptr_d      = wptr_q;
    rem_d       = rem_q;
    rd_vld_d    = 1'b0;
    hit_d       = hit_q;
    op_d        = op_q;
    res_d       = res_q;
    res_valid_d = 1'b0;
    rd_idx_d    = rd_idx_q;
    owner_d     = owner_q;
    size_d      = size_q;
    pol_d       = pol_q;
    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wdata   = OWNER_FREE;
    mem_re      = 1'b0;
    mem_raddr   = '0;
    fit_ctrl    = '0;

    unique case (state_q)
      // reset sweep, one cell a cycle
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = addr_q[IDX_W-1:0];
        addr_d    = addr_q + CNT_W'(1);
        if (addr_q == LAST_IDX) begin
          addr_d  = '0;
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (accept) begin
          op_d    = cmd_i.command;
          owner_d = cmd_i.owner_id;
          size_d  = cmd_i.request_size;
          pol_d   = cmd_i.policy;
          addr_d  = '0;
          wptr_d  = '0;
          hit_d   = 1'b0;
          unique case (cmd_i.command)
            CMD_ALLOC: begin
              // policy is checked ahead of size
              if (cmd_i.policy == POL_BAD) begin
                res_d       = make_res(ST_BAD_POLICY, '0, '0);
                res_valid_d = 1'b1;
              end else if (cmd_i.request_size == '0) begin
                res_d       = make_res(ST_NO_SPACE, '0, '0);
                res_valid_d = 1'b1;
              end else begin
                fit_ctrl.clear = 1'b1;
                state_d        = S_SCAN;
              end
            end
            CMD_FREE: begin
              if (cmd_i.owner_id == OWNER_FREE) begin
                res_d       = make_res(ST_NOT_FOUND, '0, '0);
                res_valid_d = 1'b1;
              end else begin
                state_d = S_SCAN;
              end
            end
            CMD_COMPACT: begin
              state_d = S_SCAN;
            end
            CMD_READ: begin
              if (CMP_W'(cmd_i.cell_index) < CMP_W'(CELL_COUNT)) begin
                mem_re    = 1'b1;
                mem_raddr = IDX_W'(cmd_i.cell_index);
                state_d   = S_RD_DATA;
              end else begin
                res_d       = make_res(ST_NOT_FOUND, '0, '0);
                res_valid_d = 1'b1;
              end
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end

      // read sweep; data of the previous address is handled in the same cycle
      S_SCAN: begin
        if (addr_q != END_IDX) begin
          mem_re    = 1'b1;
          mem_raddr = addr_q[IDX_W-1:0];
          addr_d    = addr_q + CNT_W'(1);
          rd_vld_d  = 1'b1;
          rd_idx_d  = addr_q[IDX_W-1:0];
        end
        if (rd_vld_q) begin
          case (op_q)
            CMD_ALLOC: begin
              fit_ctrl.step    = 1'b1;
              fit_ctrl.is_free = (mem_rdata == OWNER_FREE);
            end
            CMD_FREE: begin
              if (mem_rdata == owner_q) begin
                mem_we    = 1'b1;
                mem_waddr = rd_idx_q;
                hit_d     = 1'b1;
              end
            end
            CMD_COMPACT: begin
              // write pointer never passes the cell just read, so no clash
              if (mem_rdata != OWNER_FREE) begin
                mem_we    = 1'b1;
                mem_waddr = wptr_q[IDX_W-1:0];
                mem_wdata = mem_rdata;
                wptr_d    = wptr_q + CNT_W'(1);
              end
            end
            default: begin
            end
          endcase
        end
        if ((addr_q == END_IDX) && !rd_vld_q) begin
          case (op_q)
            CMD_ALLOC: begin
              state_d = S_TAIL;
            end
            CMD_FREE: begin
              res_d       = make_res(hit_q ? ST_OK : ST_NOT_FOUND, '0, '0);
              res_valid_d = 1'b1;
              state_d     = S_IDLE;
            end
            CMD_COMPACT: begin
              state_d = S_ZERO;
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end

      // past the map end counts as a used cell, closing any last free run
      S_TAIL: begin
        fit_ctrl.step    = 1'b1;
        fit_ctrl.is_free = 1'b0;
        state_d          = S_PICK;
      end

      S_PICK: begin
        if (fit_found) begin
          addr_d  = CNT_W'(fit_start);
          rem_d   = size_q;
          state_d = S_FILL;
        end else begin
          res_d       = make_res(ST_NO_SPACE, '0, '0);
          res_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      // granted run always lies inside the map
      S_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = addr_q[IDX_W-1:0];
        mem_wdata = owner_q;
        addr_d    = addr_q + CNT_W'(1);
        rem_d     = rem_q - SIZE_W'(1);
        if (rem_q == SIZE_W'(1)) begin
          res_d       = make_res(ST_OK, 8'(fit_start), '0);
          res_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      // free the tail left behind by compaction
      S_ZERO: begin
        if (wptr_q != END_IDX) begin
          mem_we    = 1'b1;
          mem_waddr = wptr_q[IDX_W-1:0];
          wptr_d    = wptr_q + CNT_W'(1);
        end else begin
          res_d       = make_res(ST_OK, '0, '0);
          res_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      S_RD_DATA: begin
        res_d       = make_res(ST_OK, '0, mem_rdata);
        res_valid_d = 1'b1;
        state_d     = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      addr_q      <= '0;
      wptr_q      <= '0;
      rem_q       <= '0;
      rd_vld_q    <= 1'b0;
      hit_q       <= 1'b0;
      op_q        <= CMD_ALLOC;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      addr_q      <= addr_d;
      wptr_q      <= wptr_d;
      rem_q       <= rem_d;
      rd_vld_q    <= rd_vld_d;
      hit_q       <= hit_d;
      op_q        <= op_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q    <= res_d;
    rd_idx_q <= rd_idx_d;
    owner_q  <= owner_d;
    size_q   <= size_d;
    pol_q    <= pol_d;
  end

  assign res_o       = res_q;
  assign res_valid_o = res_valid_q;

endmodule

// File: rtl/cfa_checker.sv
// port-level checks of the allocator, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cfa_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start,
  input logic          busy,
  input cfa_pkg::res_t res_o,
  input logic          res_valid_o
);

  import cfa_pkg::*;

  // an accepted command either answers at once or keeps the block busy
  `CFA_ASSERT(a_accept_reacts, (start && !busy) |=> (res_valid_o || busy), "accepted command lost")

  // a result strobe only comes once the command has finished
  `CFA_ASSERT(a_strobe_not_busy, res_valid_o |-> !busy, "result shown while busy")

  // only a granted run reports a start cell
  `CFA_ASSERT(a_start_zero, (res_valid_o && (res_o.status != ST_OK)) |-> (res_o.start_index == 8'd0), "start index on failed command")

  // no result during reset, and the clearing pass follows it
  `CFA_ASSERT_RST(a_rst_quiet, !rst_ni |-> !res_valid_o, "result strobe during reset")
  `CFA_ASSERT_RST(a_clear_after_rst, $rose(rst_ni) |-> busy, "no clearing pass after reset")

endmodule

bind contiguous_fit_allocator_top cfa_checker u_cfa_checker (.*);

// File: tb/contiguous_fit_allocator_top_tb.sv
// self-checking testbench of the contiguous fit allocator top level
`timescale 1ns / 1ps

module contiguous_fit_allocator_top_tb;
  import cfa_pkg::*;

  // map size used for the block and for the local copy of its cell map
  localparam int CELLS = 256;
  // owners drawn most of the time, so that frees usually hit something
  localparam int OWNER_POOL = 12;
  localparam int RANDOM_ITEMS = 1125;
  // the sender waits for every answer after this many random transactions
  localparam int DRAIN_EVERY = 300;
  // cycles allowed for stray results after the last answer: longer than a compact
  localparam int TAIL_CYCLES = 2 * CELLS + 16;

  typedef struct packed {
    cmd_t cmd;
    logic fixed;
    res_t want;
  } directed_row_t;

  logic clk_i;
  logic rst_ni;
  logic start_q;
  cmd_t cmd_q;
  logic busy;
  res_t res_o;
  logic res_valid_o;

  // local copy of the cell map, updated as each transaction is accepted
  logic [OWNER_W-1:0] shadow_map [CELLS];
  // answers still to come, oldest first
  res_t expected_results [$];
  res_t oldest_expected;
  directed_row_t directed_rows [$];
  int mismatch_count;
  int burst_left;

  contiguous_fit_allocator_top #(
    .CELL_COUNT(CELLS)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start_q),
    .busy       (busy),
    .cmd_i      (cmd_q),
    .res_o      (res_o),
    .res_valid_o(res_valid_o)
  );

  // 12 ns clock
  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // predicts the answer to one command and applies its effect on the cell map
  function automatic res_t apply_command(input cmd_t c);
    res_t r;
    int i;
    int size;
    int run_start;
    int run_len;
    int best_start;
    int best_len;
    int w;
    bit found;
    bit take;
    bit done;
    bit is_free;
    bit hit;
    r = '0;
    r.status = ST_OK;
    size = c.request_size;
    case (c.command)
      CMD_ALLOC: begin
        if (c.policy == POL_BAD) begin
          // policy is checked ahead of the size
          r.status = ST_BAD_POLICY;
        end else begin
          found = 1'b0;
          done = 1'b0;
          best_start = 0;
          best_len = 0;
          run_start = 0;
          run_len = 0;
          // one pass past the end closes the last free run
          for (i = 0; i <= CELLS && !done; i++) begin
            is_free = (i < CELLS) && (shadow_map[i] == OWNER_FREE);
            if (is_free) begin
              if (run_len == 0) run_start = i;
              run_len++;
            end else begin
              if (run_len >= size && run_len > 0) begin
                // strict compares keep the lowest address among equal runs
                if (!found) take = 1'b1;
                else if (c.policy == POL_BEST) take = run_len < best_len;
                else if (c.policy == POL_WORST) take = run_len > best_len;
                else take = 1'b0;
                if (take) begin
                  found = 1'b1;
                  best_start = run_start;
                  best_len = run_len;
                  if (c.policy == POL_FIRST) done = 1'b1;
                end
              end
              run_len = 0;
            end
          end
          if (size == 0 || !found) begin
            r.status = ST_NO_SPACE;
          end else begin
            // owner zero writes free cells, so the run stays free
            for (i = 0; i < size && best_start + i < CELLS; i++) begin
              shadow_map[best_start + i] = c.owner_id;
            end
            r.start_index = best_start[7:0];
          end
        end
      end
      CMD_FREE: begin
        hit = 1'b0;
        if (c.owner_id != OWNER_FREE) begin
          for (i = 0; i < CELLS; i++) begin
            if (shadow_map[i] == c.owner_id) begin
              shadow_map[i] = OWNER_FREE;
              hit = 1'b1;
            end
          end
        end
        if (!hit) r.status = ST_NOT_FOUND;
      end
      CMD_COMPACT: begin
        // slide owned cells down in order, then clear the tail
        w = 0;
        for (i = 0; i < CELLS; i++) begin
          if (shadow_map[i] != OWNER_FREE) begin
            shadow_map[w] = shadow_map[i];
            w++;
          end
        end
        for (i = w; i < CELLS; i++) shadow_map[i] = OWNER_FREE;
      end
      default: begin
        if (int'(c.cell_index) < CELLS) r.cell_value = shadow_map[c.cell_index];
        else r.status = ST_NOT_FOUND;
      end
    endcase
    return r;
  endfunction

  function automatic directed_row_t mk_row(input cmd_e cmd, input logic [7:0] owner,
                                           input logic [8:0] size, input policy_e pol,
                                           input logic [7:0] idx, input logic fixed,
                                           input status_e st, input logic [7:0] start_ix,
                                           input logic [7:0] value);
    directed_row_t row;
    row.cmd.command = cmd;
    row.cmd.owner_id = owner;
    row.cmd.request_size = size;
    row.cmd.policy = pol;
    row.cmd.cell_index = idx;
    row.fixed = fixed;
    row.want.status = st;
    row.want.start_index = start_ix;
    row.want.cell_value = value;
    return row;
  endfunction

  // random transaction: every field is noise first, then the fields that matter are shaped
  function automatic cmd_t random_command();
    cmd_t c;
    logic [$bits(cmd_t)-1:0] raw;
    int pick;
    logic [7:0] held_by;
    raw = $bits(cmd_t)'($urandom);
    c = raw;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      c.command = CMD_ALLOC;
      pick = $urandom_range(0, 99);
      if (pick < 85) c.owner_id = 8'($urandom_range(1, OWNER_POOL));
      else if (pick < 90) c.owner_id = OWNER_FREE;
      else c.owner_id = 8'($urandom_range(0, 255));
      // mostly small requests, some large ones and some that cannot fit
      pick = $urandom_range(0, 99);
      if (pick < 70) c.request_size = 9'($urandom_range(1, 16));
      else if (pick < 85) c.request_size = 9'($urandom_range(17, 64));
      else if (pick < 93) c.request_size = 9'($urandom_range(65, 256));
      else if (pick < 96) c.request_size = '0;
      else c.request_size = 9'($urandom_range(257, 511));
      if ($urandom_range(0, 19) == 0) c.policy = POL_BAD;
      else c.policy = policy_e'($urandom_range(0, 2));
    end else if (pick < 58) begin
      c.command = CMD_FREE;
      pick = $urandom_range(0, 99);
      held_by = shadow_map[$urandom_range(0, CELLS - 1)];
      if (pick < 75 && held_by != OWNER_FREE) c.owner_id = held_by;
      else if (pick < 85) c.owner_id = 8'($urandom_range(1, OWNER_POOL));
      else if (pick < 90) c.owner_id = OWNER_FREE;
      else c.owner_id = 8'($urandom_range(0, 255));
    end else if (pick < 66) begin
      c.command = CMD_COMPACT;
    end else begin
      c.command = CMD_READ;
    end
    return c;
  endfunction

  // offer one transaction and hold it until the block takes it
  task automatic issue_command(input cmd_t c, input logic fixed, input res_t want);
    res_t predicted;
    cmd_q <= c;
    start_q <= 1'b1;
    do @(posedge clk_i); while (busy !== 1'b0);
    predicted = apply_command(c);
    expected_results.push_back(fixed ? want : predicted);
  endtask

  // burst pacing of the sender: random bursts, random gaps, now and then a long gap
  task automatic pace_sender();
    int gap;
    burst_left--;
    if (burst_left <= 0) begin
      if ($urandom_range(0, 9) == 0) gap = $urandom_range(1, 600);
      else gap = $urandom_range(1, 12);
      start_q <= 1'b0;
      repeat (gap) @(posedge clk_i);
      // occasional long stretch without any gap
      if ($urandom_range(0, 7) == 0) burst_left = $urandom_range(40, 80);
      else burst_left = $urandom_range(1, 24);
    end
  endtask

  // stop sending until every outstanding answer has come back
  task automatic hold_until_answered();
    start_q <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  // report one field mismatch
  task automatic check_field(input string field, input int want, input int got);
    if (want != got) begin
      $display("%0t mismatch in %s: expected %0d, actual %0d", $time, field, want, got);
      mismatch_count++;
    end
  endtask

  // result side: every strobe is taken, the receiver never stalls
  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) begin
      if (expected_results.size() == 0) begin
        $display("%0t unexpected result: expected none, actual status %0d start %0d value %0d",
                 $time, res_o.status, res_o.start_index, res_o.cell_value);
        mismatch_count++;
      end else begin
        oldest_expected = expected_results.pop_front();
        check_field("status", oldest_expected.status, res_o.status);
        check_field("start_index", oldest_expected.start_index, res_o.start_index);
        check_field("cell_value", oldest_expected.cell_value, res_o.cell_value);
      end
    end
  end

  // run limit, well beyond the slowest correct run
  initial begin
    #100_000_000;
    $display("[contiguous_fit_allocator_top] ERROR");
    $finish;
  end

  initial begin
    rst_ni = 1'b0;
    start_q = 1'b0;
    cmd_q = '0;
    mismatch_count = 0;
    burst_left = 1;
    for (int i = 0; i < CELLS; i++) shadow_map[i] = OWNER_FREE;

    // directed transactions: answers typed in where they are plain, the rest predicted
    // read after reset, both ends of the map
    directed_rows.push_back(mk_row(CMD_READ, 0, 0, POL_FIRST, 0, 1, ST_OK, 0, 0));
    directed_rows.push_back(mk_row(CMD_READ, 0, 0, POL_FIRST, 255, 1, ST_OK, 0, 0));
    // invalid policy wins over the zero size
    directed_rows.push_back(mk_row(CMD_ALLOC, 5, 0, POL_BAD, 0, 1, ST_BAD_POLICY, 0, 0));
    directed_rows.push_back(mk_row(CMD_ALLOC, 5, 0, POL_FIRST, 0, 1, ST_NO_SPACE, 0, 0));
    // too large for the map
    directed_rows.push_back(mk_row(CMD_ALLOC, 5, 257, POL_FIRST, 0, 1, ST_NO_SPACE, 0, 0));
    // whole map to the top owner id
    directed_rows.push_back(mk_row(CMD_ALLOC, 255, 256, POL_WORST, 0, 1, ST_OK, 0, 0));
    directed_rows.push_back(mk_row(CMD_READ, 0, 0, POL_FIRST, 255, 1, ST_OK, 0, 255));
    // full map
    directed_rows.push_back(mk_row(CMD_ALLOC, 9, 1, POL_FIRST, 0, 1, ST_NO_SPACE, 0, 0));
    directed_rows.push_back(mk_row(CMD_FREE, 255, 0, POL_FIRST, 0, 1, ST_OK, 0, 0));
    // unknown owner and owner zero
    directed_rows.push_back(mk_row(CMD_FREE, 255, 0, POL_FIRST, 0, 1, ST_NOT_FOUND, 0, 0));
    directed_rows.push_back(mk_row(CMD_FREE, 0, 0, POL_FIRST, 0, 1, ST_NOT_FOUND, 0, 0));
    // four blocks of four, then holes at the first and third, for fit ties
    directed_rows.push_back(mk_row(CMD_ALLOC, 1, 4, POL_FIRST, 0, 1, ST_OK, 0, 0));
    directed_rows.push_back(mk_row(CMD_ALLOC, 2, 4, POL_BEST, 0, 0, ST_OK, 0, 0));
    directed_rows.push_back(mk_row(CMD_ALLOC, 3, 4, POL_WORST, 0, 0, ST_OK, 0, 0));
    directed_rows.push_back(mk_row(CMD_ALLOC, 4, 4, POL_FIRST, 0, 0, ST_OK, 0, 0));
    directed_rows.push_back(mk_row(CMD_FREE, 1, 0, POL_FIRST, 0, 0, ST_OK, 0, 0));
    directed_rows.push_back(mk_row(CMD_FREE, 3, 0, POL_FIRST, 0, 0, ST_OK, 0, 0));
    // best fit among two equal holes, worst fit to the big tail
    directed_rows.push_back(mk_row(CMD_ALLOC, 5, 3, POL_BEST, 0, 0, ST_OK, 0, 0));
    directed_rows.push_back(mk_row(CMD_ALLOC, 6, 2, POL_WORST, 0, 0, ST_OK, 0, 0));
    // owner zero leaves its run free, so the next request lands on it again
    directed_rows.push_back(mk_row(CMD_ALLOC, 0, 2, POL_FIRST, 0, 0, ST_OK, 0, 0));
    directed_rows.push_back(mk_row(CMD_ALLOC, 7, 4, POL_FIRST, 0, 0, ST_OK, 0, 0));
    directed_rows.push_back(mk_row(CMD_COMPACT, 0, 0, POL_FIRST, 0, 0, ST_OK, 0, 0));
    directed_rows.push_back(mk_row(CMD_READ, 0, 0, POL_FIRST, 0, 0, ST_OK, 0, 0));
    directed_rows.push_back(mk_row(CMD_READ, 0, 0, POL_FIRST, 7, 0, ST_OK, 0, 0));
    // largest size field value
    directed_rows.push_back(mk_row(CMD_ALLOC, 8, 511, POL_BEST, 0, 1, ST_NO_SPACE, 0, 0));

    // reset once; the clearing pass shows up as busy
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[k]) begin
      issue_command(directed_rows[k].cmd, directed_rows[k].fixed, directed_rows[k].want);
      if (k == directed_rows.size() - 1) hold_until_answered();
      else pace_sender();
    end

    // random transactions, with a full drain every few hundred
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      issue_command(random_command(), 1'b0, '0);
      if (n == RANDOM_ITEMS - 1 || n % DRAIN_EVERY == DRAIN_EVERY - 1) hold_until_answered();
      else pace_sender();
    end

    // nothing outstanding now; watch for stray strobes
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("[contiguous_fit_allocator_top] OK");
    end else begin
      $display("[contiguous_fit_allocator_top] ERROR");
    end
    $finish;
  end

endmodule
